/* sv/assert_macros.svh */
// Assertion macros shared by the configuration shadow RTL.
// Expects clk, and rst_n for HBCS_ASSERT, in the scope of each use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HBCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HBCS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBCS_ASSERT(lbl, prop, msg)
`define HBCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* sv/hbcs_pkg.sv */
// Types, address codes and reset contents of the host bridge configuration space.
// No dependencies.
`default_nettype none

package hbcs_pkg;

    localparam int CFG_DEPTH = 256;
    localparam int MAP_W     = 4;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [2:0] FUNC_HOST = 3'd0;

    localparam logic [7:0] ADDR_ID_LO     = 8'h00;
    localparam logic [7:0] ADDR_ID_HI     = 8'h03;
    localparam logic [7:0] ADDR_CMD_LO    = 8'h04;
    localparam logic [7:0] ADDR_CMD_HI    = 8'h05;
    localparam logic [7:0] ADDR_STAT_LO   = 8'h06;
    localparam logic [7:0] ADDR_STAT_HI   = 8'h07;
    localparam logic [7:0] ADDR_CLASS_LO  = 8'h08;
    localparam logic [7:0] ADDR_CLASS_HI  = 8'h0C;
    localparam logic [7:0] ADDR_HDR_TYPE  = 8'h0E;
    localparam logic [7:0] ADDR_BAR_LO    = 8'h10;
    localparam logic [7:0] ADDR_BAR_HI    = 8'h4E;
    localparam logic [7:0] ADDR_DEF0      = 8'h50;
    localparam logic [7:0] ADDR_DEF1      = 8'h51;
    localparam logic [7:0] ADDR_DEF2      = 8'h52;
    localparam logic [7:0] ADDR_SHADOW_CTL = 8'h53;
    localparam logic [7:0] ADDR_SHADOW_EN = 8'h54;

    localparam logic [7:0] CMD_LO_MASK  = 8'h42;
    localparam logic [7:0] CMD_LO_SET   = 8'h04;
    localparam logic [7:0] CMD_HI_MASK  = 8'h01;
    localparam logic [7:0] STAT_LO_VAL  = 8'h00;
    localparam logic [7:0] STAT_HI_VAL  = 8'h02;
    localparam logic [7:0] SHADOW_HOLD  = 8'hF0;
    localparam logic [7:0] NO_FUNC_DATA = 8'hFF;

    localparam int CTL_RD_INT_BIT  = 6;
    localparam int CTL_WR_EXT_BIT  = 5;
    localparam int EN_FIRST_BIT    = 4;

    localparam logic [7:0] RST_SHADOW_CTL = 8'hFE;
    localparam logic [7:0] RST_SHADOW_EN  = 8'h00;

    typedef struct packed {
        logic       mode;
        logic [2:0] func;
        logic [7:0] addr;
        logic [7:0] write_data;
    } req_word_t;

    typedef struct packed {
        logic [7:0]       read_data;
        logic             remapped;
        logic [MAP_W-1:0] seg_read_internal;
        logic [MAP_W-1:0] seg_write_internal;
    } rsp_word_t;

    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } mem_wr_t;

    function automatic logic [7:0] reset_byte(input logic [7:0] addr);
        logic [7:0] val;
        unique case (addr)
            8'h00:           val = 8'h39;
            8'h01:           val = 8'h10;
            8'h02:           val = 8'h06;
            8'h03:           val = 8'h04;
            ADDR_CMD_LO:     val = 8'h07;
            ADDR_STAT_LO:    val = 8'h80;
            ADDR_STAT_HI:    val = 8'h02;
            ADDR_DEF0:       val = 8'hBC;
            ADDR_DEF1:       val = 8'hFB;
            ADDR_DEF2:       val = 8'hAD;
            ADDR_SHADOW_CTL: val = RST_SHADOW_CTL;
            default:         val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

/* sv/hbcs_mem.sv */
// Configuration byte RAM: one write port, one registered read port, per-byte valid bits.
// Unwritten bytes read as their reset contents. Depends on hbcs_pkg.
`default_nettype none
`include "assert_macros.svh"

module hbcs_mem
    import hbcs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire mem_wr_t wr,
    input  wire logic    rd_en,
    input  wire logic [7:0] rd_addr,
    output logic [7:0]   rd_data
);

    logic [7:0]           mem_reg [CFG_DEPTH];
    logic [CFG_DEPTH-1:0] vld_reg;
    logic [7:0]           data_reg;
    logic [7:0]           addr_reg;
    logic                 hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            data_reg <= mem_reg[rd_addr];
            addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : reset_byte(addr_reg);

    `HBCS_ASSERT(a_wr_marks_valid, wr.we |=> vld_reg[$past(wr.addr)], "written byte not valid")

endmodule

`default_nettype wire

/* sv/hbcs_ctrl.sv */
// Write rules per address, shadow control mirrors and shadow segment maps.
// Drives the RAM write port. Depends on hbcs_pkg.
`default_nettype none
`include "assert_macros.svh"

module hbcs_ctrl
    import hbcs_pkg::*;
#(
    parameter int SHADOW_SEGMENTS = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  wire req_word_t req,
    output mem_wr_t        wr,
    output logic           remap,
    output logic [MAP_W-1:0] map_rd_reg,
    output logic [MAP_W-1:0] map_wr_reg
);

    localparam logic [MAP_W-1:0] SEG_MASK = MAP_W'((1 << SHADOW_SEGMENTS) - 1);

    logic [7:0]       ctl_reg;
    logic [7:0]       en_reg;
    logic             keep;
    logic             hold_hit;
    logic [7:0]       data;
    logic             host_wr;
    logic [MAP_W-1:0] map_rd_next;
    logic [MAP_W-1:0] map_wr_next;

    always_comb
    begin
        keep     = 1'b1;
        hold_hit = 1'b0;
        data     = req.write_data;
        unique case (req.addr) inside
            [ADDR_ID_LO:ADDR_ID_HI], [ADDR_CLASS_LO:ADDR_CLASS_HI], ADDR_HDR_TYPE,
            [ADDR_BAR_LO:ADDR_BAR_HI]:
                keep = 1'b0;
            ADDR_CMD_LO:  data = (req.write_data & CMD_LO_MASK) | CMD_LO_SET;
            ADDR_CMD_HI:  data = req.write_data & CMD_HI_MASK;
            ADDR_STAT_LO: data = STAT_LO_VAL;
            ADDR_STAT_HI: data = STAT_HI_VAL;
            ADDR_SHADOW_EN:
                hold_hit = ((en_reg & req.write_data) == SHADOW_HOLD);
            default: ;
        endcase
        host_wr = fire && (req.mode == MODE_WRITE) && (req.func == FUNC_HOST);
        wr.we   = host_wr && keep;
        wr.addr = req.addr;
        wr.data = data;
        remap   = host_wr && (req.addr == ADDR_SHADOW_EN) && !hold_hit;
    end

    always_comb
    begin
        map_rd_next = '0;
        map_wr_next = '0;
        for (int i = 0; i < SHADOW_SEGMENTS; i++)
        begin
            map_rd_next[i] = req.write_data[EN_FIRST_BIT + i] && ctl_reg[CTL_RD_INT_BIT];
            map_wr_next[i] = req.write_data[EN_FIRST_BIT + i] && !ctl_reg[CTL_WR_EXT_BIT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg    <= RST_SHADOW_CTL;
            en_reg     <= RST_SHADOW_EN;
            map_rd_reg <= '0;
            map_wr_reg <= '0;
        end
        else
        begin
            if (host_wr && req.addr == ADDR_SHADOW_CTL)
            begin
                ctl_reg <= req.write_data;
            end
            if (host_wr && req.addr == ADDR_SHADOW_EN)
            begin
                en_reg <= req.write_data;
            end
            if (remap)
            begin
                map_rd_reg <= map_rd_next;
                map_wr_reg <= map_wr_next;
            end
        end
    end

    `HBCS_ASSERT(a_map_only_on_remap, !remap |=> $stable(map_rd_reg) && $stable(map_wr_reg), "map moved without remap")
    `HBCS_ASSERT_ALWAYS(a_map_unused_segs, ((map_rd_reg | map_wr_reg) & ~SEG_MASK) == '0, "map bit beyond segments")

endmodule

`default_nettype wire

/* sv/pci_host_bridge_config_shadow.sv */
// Top level of the host bridge configuration space with shadow map control.
// Instantiates hbcs_ctrl and hbcs_mem. Depends on hbcs_pkg.
//
//   channel  dir  handshake              word
//   req      in   req_valid / req_stall  req_word_t: mode, func, addr, write_data
//   rsp      out  rsp_valid / rsp_stall  rsp_word_t: read_data, remapped, maps
//
// One word per cycle while req_stall is low; its result appears the cycle after acceptance (RAM read latency).
// Kept host writes update the RAM at the accept edge, so a following read sees them.
// Reset clears the byte valid bits at once; no clearing pass, words taken right away.
// A stalled result holds, and req_stall rises until it is taken.
`default_nettype none
`include "assert_macros.svh"

module pci_host_bridge_config_shadow
    import hbcs_pkg::*;
#(
    parameter int SHADOW_SEGMENTS = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_word_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp
);

    logic             fire;
    mem_wr_t          wr;
    logic             remap;
    logic [MAP_W-1:0] map_rd;
    logic [MAP_W-1:0] map_wr;
    logic [7:0]       mem_data;

    logic s1_vld_reg, s1_vld_next;
    logic s1_rd_reg;
    logic s1_fnz_reg;
    logic s1_remap_reg;

    assign req_stall = s1_vld_reg && rsp_stall;
    assign fire      = req_valid && !req_stall;

    hbcs_ctrl #(
        .SHADOW_SEGMENTS(SHADOW_SEGMENTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .req        (req),
        .wr         (wr),
        .remap      (remap),
        .map_rd_reg (map_rd),
        .map_wr_reg (map_wr)
    );

    hbcs_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_en   (fire),
        .rd_addr (req.addr),
        .rd_data (mem_data)
    );

    always_comb
    begin
        if (fire)
        begin
            s1_vld_next = 1'b1;
        end
        else
        begin
            s1_vld_next = s1_vld_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s1_rd_reg    <= 1'b0;
            s1_fnz_reg   <= 1'b0;
            s1_remap_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            if (fire)
            begin
                s1_rd_reg    <= (req.mode == MODE_READ);
                s1_fnz_reg   <= (req.func != FUNC_HOST);
                s1_remap_reg <= remap;
            end
        end
    end

    always_comb
    begin
        rsp_valid = s1_vld_reg;
        if (!s1_rd_reg)
        begin
            rsp.read_data = '0;
        end
        else if (s1_fnz_reg)
        begin
            rsp.read_data = NO_FUNC_DATA;
        end
        else
        begin
            rsp.read_data = mem_data;
        end
        rsp.remapped           = s1_remap_reg;
        rsp.seg_read_internal  = map_rd;
        rsp.seg_write_internal = map_wr;
    end

    `HBCS_ASSERT(a_read_no_remap, fire && req.mode == MODE_READ |=> !rsp.remapped, "read reported remap")
    `HBCS_ASSERT(a_remap_zero_data, rsp_valid && rsp.remapped |-> rsp.read_data == '0, "remap with read data")

endmodule

`default_nettype wire
